// ----- rtl/tti_pkg.sv -----
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants and types for the thermistor table interpolator: the
// calibration table, register indexes and the tag carried through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int CAL_POINTS_N = 12;
  localparam int NUM_SEGS     = CAL_POINTS_N - 1;
  localparam int SEG_W        = $clog2(NUM_SEGS);
  localparam int CAL_W        = 12;

  // every span of the table is wider than 2**SPAN_LOG2_MIN
  localparam int SPAN_LOG2_MIN = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int LIMIT_W    = 12;
  localparam int BASE_W     = 8;
  localparam int OUT_W      = 16;

  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 12'd700;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 12'd2736;
  localparam logic [BASE_W-1:0]  BASE_TEMP_RESET  = 8'd46;

  localparam logic [CAL_W-1:0] CAL_POINTS [CAL_POINTS_N] = '{
    12'd828,  12'd1017, 12'd1204, 12'd1386, 12'd1565, 12'd1741,
    12'd1912, 12'd2080, 12'd2245, 12'd2406, 12'd2563, 12'd2716
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_LOW   = 2'd0,
    CFG_ADC_HIGH  = 2'd1,
    CFG_BASE_TEMP = 2'd2
  } tti_cfg_idx_t;

  // classification of one sample, travels with the raw sample
  typedef struct packed {
    logic                     in_range;
    logic [SEG_W-1:0]         seg;
    logic signed [BASE_W-1:0] base;
  } tti_tag_t;

  function automatic logic [CAL_W-1:0] seg_span(input int unsigned s);
    return CAL_POINTS[s+1] - CAL_POINTS[s];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tti_front.sv -----
// ----------------------------------------------------------------------------
// tti_front
// Holds the configuration registers, takes samples in, checks them against
// the limits and picks the table segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_front
  import tti_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12,
  parameter int ADC_BITS      = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADC_BITS-1:0]   in_raw_sample,
  input  wire logic                  q_full,
  output logic                       q_push,
  output tti_tag_t                   q_tag
);

  localparam int USED_POINTS = (TABLE_ENTRIES < CAL_POINTS_N) ?
                               ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES) : CAL_POINTS_N;
  localparam int LAST_SEG    = USED_POINTS - 2;
  localparam int CMP_W       = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;

  logic [LIMIT_W-1:0] low_r,  low_nxt;
  logic [LIMIT_W-1:0] high_r, high_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;

  logic [CMP_W-1:0]   raw_ext;
  logic [SEG_W-1:0]   seg;

  assign cfg_ready = 1'b1;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    base_nxt = base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADC_LOW:   low_nxt  = cfg_wdata[LIMIT_W-1:0];
        CFG_ADC_HIGH:  high_nxt = cfg_wdata[LIMIT_W-1:0];
        CFG_BASE_TEMP: base_nxt = cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_LIMIT_RESET;
      high_r <= HIGH_LIMIT_RESET;
      base_r <= BASE_TEMP_RESET;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      base_r <= base_nxt;
    end
  end

  assign raw_ext = CMP_W'(in_raw_sample);

  // last segment whose start is at or below the sample, segment 0 if none
  always_comb begin
    seg = '0;
    for (int i = 1; i <= LAST_SEG; i++) begin
      if (CMP_W'(CAL_POINTS[i]) <= raw_ext) seg = SEG_W'(i);
    end
  end

  assign q_tag.in_range = (raw_ext > CMP_W'(low_r)) && (raw_ext < CMP_W'(high_r));
  assign q_tag.seg      = seg;
  assign q_tag.base     = base_r;

  assign busy   = !rst_n || q_full;
  assign q_push = start && !busy;

endmodule

`default_nettype wire

// ----- rtl/tti_queue.sv -----
// ----------------------------------------------------------------------------
// tti_queue
// Small first-in first-out queue between the classifying front and the
// arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_queue #(
  parameter int DW    = 25,
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          pop,
  output logic    [DW-1:0]   rdata,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

// ----- rtl/tti_back.sv -----
// ----------------------------------------------------------------------------
// tti_back
// Five-stage interpolation pipeline: offset into the segment, reciprocal
// multiply, remainder check, sign and correction, then sum and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_back
  import tti_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire tti_tag_t               in_tag,
  input  wire logic [ADC_BITS-1:0]    in_raw,
  output logic                        out_valid,
  output logic signed [OUT_W-1:0]     out_temp_q8,
  output logic                        out_in_range
);

  localparam int CMP_W  = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
  localparam int DIFF_W = CMP_W + 1;
  localparam int NUM_W  = CMP_W + FRAC_BITS;
  localparam int RCP_W  = NUM_W - SPAN_LOG2_MIN;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int QW     = RCP_W;
  localparam int QS_W   = QW + CAL_W;
  localparam int FW     = QW + 1;
  localparam int HI_W   = BASE_W + 1 + FRAC_BITS;
  localparam int MAX_HF = (HI_W > FW) ? HI_W : FW;
  localparam int SUM_W  = ((MAX_HF > OUT_W) ? MAX_HF : OUT_W) + 1;

  // floor(2**NUM_W / span): quotient estimate is low by at most one
  logic [RCP_W-1:0] rcp_tab  [NUM_SEGS];
  logic [CAL_W-1:0] span_tab [NUM_SEGS];

  for (genvar g = 0; g < NUM_SEGS; g++) begin : g_rcp
    localparam longint unsigned SPAN = longint'(seg_span(g));
    localparam longint unsigned RCP  = (64'd1 << NUM_W) / SPAN;
    assign rcp_tab[g]  = RCP_W'(RCP);
    assign span_tab[g] = CAL_W'(SPAN);
  end

  // stage 0
  logic                    v0_r,    v0_nxt;
  logic                    rng0_r,  rng0_nxt;
  logic                    neg0_r,  neg0_nxt;
  logic [NUM_W-1:0]        num0_r,  num0_nxt;
  logic [RCP_W-1:0]        rcp0_r,  rcp0_nxt;
  logic [CAL_W-1:0]        span0_r, span0_nxt;
  logic signed [HI_W-1:0]  hi0_r,   hi0_nxt;
  // stage 1
  logic                    v1_r,    v1_nxt;
  logic                    rng1_r,  rng1_nxt;
  logic                    neg1_r,  neg1_nxt;
  logic [NUM_W-1:0]        num1_r,  num1_nxt;
  logic [PROD_W-1:0]       prod1_r, prod1_nxt;
  logic [CAL_W-1:0]        span1_r, span1_nxt;
  logic signed [HI_W-1:0]  hi1_r,   hi1_nxt;
  // stage 2
  logic                    v2_r,    v2_nxt;
  logic                    rng2_r,  rng2_nxt;
  logic                    neg2_r,  neg2_nxt;
  logic [NUM_W-1:0]        num2_r,  num2_nxt;
  logic [QW-1:0]           q2_r,    q2_nxt;
  logic [QS_W-1:0]         qs2_r,   qs2_nxt;
  logic [CAL_W-1:0]        span2_r, span2_nxt;
  logic signed [HI_W-1:0]  hi2_r,   hi2_nxt;
  // stage 3
  logic                    v3_r,    v3_nxt;
  logic                    rng3_r,  rng3_nxt;
  logic signed [FW-1:0]    frac3_r, frac3_nxt;
  logic signed [HI_W-1:0]  hi3_r,   hi3_nxt;
  // output
  logic                    vo_r,    vo_nxt;
  logic                    rngo_r,  rngo_nxt;
  logic signed [OUT_W-1:0] temp_r,  temp_nxt;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic signed [BASE_W:0]   whole;
  logic [NUM_W-1:0]         rem;
  logic [QW-1:0]            q_fix;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-OUT_W:0]     top_bits;

  // stage 0: signed offset into the segment and the integer part
  always_comb begin
    diff      = signed'({1'b0, CMP_W'(in_raw)}) -
                signed'({1'b0, CMP_W'(CAL_POINTS[in_tag.seg])});
    mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    whole     = signed'({in_tag.base[BASE_W-1], in_tag.base}) +
                signed'({1'b0, (BASE_W)'(in_tag.seg)});
    v0_nxt    = in_valid;
    rng0_nxt  = in_tag.in_range;
    neg0_nxt  = diff[DIFF_W-1];
    num0_nxt  = {mag[CMP_W-1:0], {FRAC_BITS{1'b0}}};
    rcp0_nxt  = rcp_tab[in_tag.seg];
    span0_nxt = span_tab[in_tag.seg];
    hi0_nxt   = {whole, {FRAC_BITS{1'b0}}};
  end

  // stage 1: reciprocal multiply
  always_comb begin
    v1_nxt    = v0_r;
    rng1_nxt  = rng0_r;
    neg1_nxt  = neg0_r;
    num1_nxt  = num0_r;
    prod1_nxt = PROD_W'(num0_r) * PROD_W'(rcp0_r);
    span1_nxt = span0_r;
    hi1_nxt   = hi0_r;
  end

  // stage 2: estimate times span, for the remainder
  always_comb begin
    v2_nxt    = v1_r;
    rng2_nxt  = rng1_r;
    neg2_nxt  = neg1_r;
    num2_nxt  = num1_r;
    q2_nxt    = prod1_r[PROD_W-1:NUM_W];
    qs2_nxt   = QS_W'(prod1_r[PROD_W-1:NUM_W]) * QS_W'(span1_r);
    span2_nxt = span1_r;
    hi2_nxt   = hi1_r;
  end

  // stage 3: bump the estimate if a whole span is left, then apply sign
  always_comb begin
    rem       = num2_r - NUM_W'(qs2_r);
    q_fix     = (rem >= NUM_W'(span2_r)) ? q2_r + 1'b1 : q2_r;
    v3_nxt    = v2_r;
    rng3_nxt  = rng2_r;
    frac3_nxt = neg2_r ? -signed'({1'b0, q_fix}) : signed'({1'b0, q_fix});
    hi3_nxt   = hi2_r;
  end

  // output: sum and clamp to the 16-bit range; out-of-range samples give zero
  always_comb begin
    sum      = SUM_W'(hi3_r) + SUM_W'(frac3_r);
    top_bits = sum[SUM_W-1:OUT_W-1];
    vo_nxt   = v3_r;
    rngo_nxt = rng3_r;
    if (!rng3_r) begin
      temp_nxt = '0;
    end else if ((top_bits == '0) || (top_bits == '1)) begin
      temp_nxt = sum[OUT_W-1:0];
    end else if (sum[SUM_W-1]) begin
      temp_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      temp_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rng0_r  <= rng0_nxt;
    neg0_r  <= neg0_nxt;
    num0_r  <= num0_nxt;
    rcp0_r  <= rcp0_nxt;
    span0_r <= span0_nxt;
    hi0_r   <= hi0_nxt;
    rng1_r  <= rng1_nxt;
    neg1_r  <= neg1_nxt;
    num1_r  <= num1_nxt;
    prod1_r <= prod1_nxt;
    span1_r <= span1_nxt;
    hi1_r   <= hi1_nxt;
    rng2_r  <= rng2_nxt;
    neg2_r  <= neg2_nxt;
    num2_r  <= num2_nxt;
    q2_r    <= q2_nxt;
    qs2_r   <= qs2_nxt;
    span2_r <= span2_nxt;
    hi2_r   <= hi2_nxt;
    rng3_r  <= rng3_nxt;
    frac3_r <= frac3_nxt;
    hi3_r   <= hi3_nxt;
    rngo_r  <= rngo_nxt;
    temp_r  <= temp_nxt;
  end

  assign out_valid    = vo_r;
  assign out_temp_q8  = temp_r;
  assign out_in_range = rngo_r;

endmodule

`default_nettype wire

// ----- rtl/thermistor_table_interpolator.sv -----
// An accepted sample enters the queue, then the pipeline stages, before the result strobe.
// Throughput: one sample per cycle; the five-stage reciprocal-multiply pipeline
// behind a two-entry queue takes a new item every cycle.
// busy is high only during reset; results cannot be stalled.
// Synchronous active-low reset restores the register defaults and empties
// the queue and the pipeline.
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Converts a thermistor ADC sample into a Q8 temperature by piecewise linear
// interpolation over a fixed calibration table.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_table_interpolator
  import tti_pkg::*;
#(
  parameter int TABLE_ENTRIES = 12,
  parameter int ADC_BITS      = 12,
  parameter int FRAC_BITS     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADC_BITS-1:0]   in_raw_sample,
  output logic                       out_valid,
  output logic signed [OUT_W-1:0]    out_temp_q8,
  output logic                       out_in_range,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TAG_W = $bits(tti_tag_t);
  localparam int Q_DW  = TAG_W + ADC_BITS;

  logic                q_push;
  logic                q_pop;
  logic                q_empty;
  logic                q_full;
  tti_tag_t            push_tag;
  tti_tag_t            pop_tag;
  logic [Q_DW-1:0]     q_wdata;
  logic [Q_DW-1:0]     q_rdata;
  logic [ADC_BITS-1:0] pop_raw;

  tti_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADC_BITS      (ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_raw_sample (in_raw_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_tag         (push_tag)
  );

  assign q_wdata = {push_tag, in_raw_sample};

  tti_queue #(
    .DW    (Q_DW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // the back end never stalls, so it drains one entry each cycle while the queue is not empty
  assign q_pop   = !q_empty;
  assign pop_tag = q_rdata[Q_DW-1:ADC_BITS];
  assign pop_raw = q_rdata[ADC_BITS-1:0];

  tti_back #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (q_pop),
    .in_tag       (pop_tag),
    .in_raw       (pop_raw),
    .out_valid    (out_valid),
    .out_temp_q8  (out_temp_q8),
    .out_in_range (out_in_range)
  );

endmodule

`default_nettype wire

// ----- rtl/tti_checker.sv -----
// ----------------------------------------------------------------------------
// tti_sva_checker
// Port-level checks on the interpolator: fixed latency, one result per
// transfer, zeroed temperature for out-of-range samples, and busy never high.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_sva_checker
  import tti_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [OUT_W-1:0]      out_temp_q8,
  input wire logic                  out_in_range
);

  localparam int LATENCY = 6;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted sample produced no result on time");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_temp_q8 == '0))
    else $error("out-of-range result carries a temperature");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("queue filled up although the back end never stalls");

endmodule

bind thermistor_table_interpolator tti_sva_checker u_tti_checker (.*);

`default_nettype wire
